// ----- rtl/pcls_pkg.sv -----
// Shared types and constants for the positional circular list store.
`timescale 1ns / 1ps
`default_nettype none

package pcls_pkg;

  localparam int OP_W      = 3;
  localparam int POS_W     = 8;
  localparam int VAL_W     = 32;
  localparam int ST_W      = 2;
  localparam int CNT_OUT_W = 5;
  localparam int BIT_CNT_W = $clog2(POS_W);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_READ    = 3'd2,
    OP_REVERSE = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_RD_FIRST,
    S_RD_SECOND,
    S_REV_LOAD,
    S_REV_LO,
    S_REV_HI,
    S_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic div_step;
    logic rd_first;
    logic rd_second;
    logic rev_load;
    logic rev_write_lo;
    logic rev_write_hi;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            div_last;
    logic            rev_done;
    logic            out_busy;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/pcls_ctrl.sv -----
// Controller state machine that sequences each list command.
`timescale 1ns / 1ps
`default_nettype none

module pcls_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  pcls_pkg::sts_t     sts,
  output pcls_pkg::cmd_t     cmd
);

  pcls_pkg::state_t state_r;
  pcls_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcls_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      pcls_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = pcls_pkg::S_EXEC;
        end
      end
      pcls_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.op == pcls_pkg::OP_READ && !sts.empty) begin
          state_nxt = pcls_pkg::S_DIV;
        end else if (sts.op == pcls_pkg::OP_REVERSE && !sts.empty) begin
          state_nxt = pcls_pkg::S_REV_LOAD;
        end else begin
          state_nxt = pcls_pkg::S_DONE;
        end
      end
      pcls_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = pcls_pkg::S_RD_FIRST;
        end
      end
      pcls_pkg::S_RD_FIRST: begin
        cmd.rd_first = 1'b1;
        state_nxt    = pcls_pkg::S_RD_SECOND;
      end
      pcls_pkg::S_RD_SECOND: begin
        cmd.rd_second = 1'b1;
        state_nxt     = pcls_pkg::S_DONE;
      end
      pcls_pkg::S_REV_LOAD: begin
        if (sts.rev_done) begin
          state_nxt = pcls_pkg::S_DONE;
        end else begin
          cmd.rev_load = 1'b1;
          state_nxt    = pcls_pkg::S_REV_LO;
        end
      end
      pcls_pkg::S_REV_LO: begin
        cmd.rev_write_lo = 1'b1;
        state_nxt        = pcls_pkg::S_REV_HI;
      end
      pcls_pkg::S_REV_HI: begin
        cmd.rev_write_hi = 1'b1;
        state_nxt        = pcls_pkg::S_REV_LOAD;
      end
      pcls_pkg::S_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = pcls_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pcls_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/pcls_dp.sv -----
// Datapath with the element cells, count, modulo unit and result register.
`timescale 1ns / 1ps
`default_nettype none

module pcls_dp #(
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic        [pcls_pkg::OP_W-1:0]     in_operation,
  input  wire logic        [pcls_pkg::POS_W-1:0]    in_position,
  input  wire logic signed [pcls_pkg::VAL_W-1:0]    in_value,
  input  pcls_pkg::cmd_t                            cmd,
  output pcls_pkg::sts_t                            sts,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic             [pcls_pkg::ST_W-1:0]     out_status,
  output logic             [pcls_pkg::CNT_OUT_W-1:0] out_element_count,
  output logic signed      [pcls_pkg::VAL_W-1:0]    out_read_value,
  output logic signed      [pcls_pkg::VAL_W-1:0]    out_successor_value
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > pcls_pkg::POS_W) ? CNT_W : pcls_pkg::POS_W;

  logic        [pcls_pkg::OP_W-1:0]      op_r;
  logic        [pcls_pkg::POS_W-1:0]     pos_r;
  logic signed [pcls_pkg::VAL_W-1:0]     val_r;
  logic        [pcls_pkg::POS_W-1:0]     div_r;
  logic        [pcls_pkg::BIT_CNT_W-1:0] bit_cnt_r;
  logic        [CNT_W-1:0]               rem_r;
  logic        [IDX_W-1:0]               nxt_r;
  logic        [IDX_W-1:0]               lo_r;
  logic        [IDX_W-1:0]               hi_r;
  logic signed [pcls_pkg::VAL_W-1:0]     tmp_r;
  logic signed [pcls_pkg::VAL_W-1:0]     cells_r   [DEPTH];
  logic signed [pcls_pkg::VAL_W-1:0]     cells_nxt [DEPTH];
  logic        [CNT_W-1:0]               count_r;
  logic        [CNT_W-1:0]               count_nxt;
  pcls_pkg::status_t                     res_status_r;
  logic signed [pcls_pkg::VAL_W-1:0]     res_rd_r;
  logic signed [pcls_pkg::VAL_W-1:0]     res_succ_r;
  logic                                  out_valid_r;
  pcls_pkg::status_t                     out_status_r;
  logic        [CNT_W-1:0]               out_count_r;
  logic signed [pcls_pkg::VAL_W-1:0]     out_rd_r;
  logic signed [pcls_pkg::VAL_W-1:0]     out_succ_r;

  logic        [CMP_W-1:0]               pos_ext;
  logic        [CMP_W-1:0]               cnt_ext;
  logic                                  ins_range;
  logic                                  full;
  logic                                  rem_range;
  logic                                  empty;
  logic                                  do_insert;
  logic                                  do_remove;
  pcls_pkg::status_t                     ex_status;
  logic        [IDX_W-1:0]               rd_addr;
  logic signed [pcls_pkg::VAL_W-1:0]     rdata;
  logic        [CNT_W:0]                 div_trial;
  logic        [CNT_W:0]                 div_cnt;
  logic        [CNT_W-1:0]               div_rem_nxt;
  logic        [CNT_W-1:0]               rem_inc;
  logic        [CNT_W-1:0]               cnt_m1;
  logic        [CNT_W+pcls_pkg::CNT_OUT_W-1:0] cnt_out_ext;

  assign pos_ext   = CMP_W'(pos_r);
  assign cnt_ext   = CMP_W'(count_r);
  assign ins_range = pos_ext > cnt_ext;
  assign full      = count_r == CNT_W'(DEPTH);
  assign rem_range = pos_ext >= cnt_ext;
  assign empty     = count_r == '0;
  assign do_insert = cmd.exec && op_r == pcls_pkg::OP_INSERT && !ins_range && !full;
  assign do_remove = cmd.exec && op_r == pcls_pkg::OP_REMOVE && !rem_range;

  always_comb begin
    case (op_r)
      pcls_pkg::OP_INSERT: begin
        if (ins_range) begin
          ex_status = pcls_pkg::ST_RANGE;
        end else if (full) begin
          ex_status = pcls_pkg::ST_FULL;
        end else begin
          ex_status = pcls_pkg::ST_OK;
        end
      end
      pcls_pkg::OP_REMOVE: begin
        ex_status = rem_range ? pcls_pkg::ST_RANGE : pcls_pkg::ST_OK;
      end
      pcls_pkg::OP_READ, pcls_pkg::OP_REVERSE: begin
        ex_status = empty ? pcls_pkg::ST_EMPTY : pcls_pkg::ST_OK;
      end
      default: begin
        ex_status = pcls_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (do_insert) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_remove) begin
      count_nxt = count_r - CNT_W'(1);
    end else if (cmd.exec && op_r == pcls_pkg::OP_CLEAR) begin
      count_nxt = '0;
    end
  end

  always_comb begin
    if (cmd.rd_first) begin
      rd_addr = rem_r[IDX_W-1:0];
    end else if (cmd.rd_second) begin
      rd_addr = nxt_r;
    end else if (cmd.rev_load) begin
      rd_addr = lo_r;
    end else begin
      rd_addr = hi_r;
    end
  end

  assign rdata = cells_r[rd_addr];

  assign div_trial   = {rem_r, div_r[pcls_pkg::POS_W-1]};
  assign div_cnt     = {1'b0, count_r};
  assign div_rem_nxt = (div_trial >= div_cnt) ? CNT_W'(div_trial - div_cnt)
                                              : CNT_W'(div_trial);
  assign rem_inc     = rem_r + CNT_W'(1);
  assign cnt_m1      = count_r - CNT_W'(1);

  always_comb begin
    cells_nxt = cells_r;
    if (do_insert) begin
      if (pos_r == '0) begin
        cells_nxt[0] = val_r;
      end
      for (int i = 1; i < DEPTH; i++) begin
        if (pcls_pkg::POS_W'(i) == pos_r) begin
          cells_nxt[i] = val_r;
        end else if (pcls_pkg::POS_W'(i) > pos_r) begin
          cells_nxt[i] = cells_r[i-1];
        end
      end
    end else if (do_remove) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (pcls_pkg::POS_W'(i) >= pos_r) begin
          cells_nxt[i] = cells_r[i+1];
        end
      end
    end else if (cmd.rev_write_lo) begin
      cells_nxt[lo_r] = rdata;
    end else if (cmd.rev_write_hi) begin
      cells_nxt[hi_r] = tmp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cells_r <= cells_nxt;
    if (cmd.latch) begin
      op_r  <= in_operation;
      pos_r <= in_position;
      val_r <= in_value;
    end
    if (cmd.exec) begin
      res_status_r <= ex_status;
      res_rd_r     <= '0;
      res_succ_r   <= '0;
      rem_r        <= '0;
      div_r        <= pos_r;
      bit_cnt_r    <= '0;
      lo_r         <= '0;
      hi_r         <= cnt_m1[IDX_W-1:0];
    end
    if (cmd.div_step) begin
      rem_r     <= div_rem_nxt;
      div_r     <= div_r << 1;
      bit_cnt_r <= bit_cnt_r + pcls_pkg::BIT_CNT_W'(1);
    end
    if (cmd.rd_first) begin
      res_rd_r <= rdata;
      nxt_r    <= (rem_inc >= count_r) ? '0 : rem_inc[IDX_W-1:0];
    end
    if (cmd.rd_second) begin
      res_succ_r <= rdata;
    end
    if (cmd.rev_load) begin
      tmp_r <= rdata;
    end
    if (cmd.rev_write_hi) begin
      lo_r <= lo_r + IDX_W'(1);
      hi_r <= hi_r - IDX_W'(1);
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_count_r  <= count_r;
      out_rd_r     <= res_rd_r;
      out_succ_r   <= res_succ_r;
    end
  end

  assign sts.op       = op_r;
  assign sts.empty    = empty;
  assign sts.div_last = bit_cnt_r == pcls_pkg::BIT_CNT_W'(pcls_pkg::POS_W - 1);
  assign sts.rev_done = !(lo_r < hi_r);
  assign sts.out_busy = out_valid_r && !out_ready;

  assign cnt_out_ext         = {{pcls_pkg::CNT_OUT_W{1'b0}}, out_count_r};
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_element_count   = cnt_out_ext[pcls_pkg::CNT_OUT_W-1:0];
  assign out_read_value      = out_rd_r;
  assign out_successor_value = out_succ_r;

endmodule

`default_nettype wire

// ----- rtl/positional_circular_list_store_top.sv -----
// Top level of the positional circular list store.
`timescale 1ns / 1ps
`default_nettype none

// The block holds an ordered list of up to DEPTH signed 32-bit values and runs one command per
// item: insert, remove, read with circular successor, reverse and clear. Each item yields one
// result with a status and the new count (the low five bits of it). One item is worked at a
// time. Insert, remove, clear and unused codes pass through S_EXEC and S_DONE: all cells shift
// at once in S_EXEC. A read runs a one-bit-per-cycle restoring modulo over the 8-bit position,
// then two reads through the single cell read port. A reverse does floor(count / 2) swaps, each
// through that port in S_REV_LOAD, S_REV_LO and S_REV_HI. The result register lets a new item
// be accepted while the previous result still waits. Reset clears the count and the output
// valid flag only; no clearing pass runs over the cells.
module positional_circular_list_store_top #(
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic        [pcls_pkg::OP_W-1:0]      in_operation,
  input  wire logic        [pcls_pkg::POS_W-1:0]     in_position,
  input  wire logic signed [pcls_pkg::VAL_W-1:0]     in_value,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic             [pcls_pkg::ST_W-1:0]      out_status,
  output logic             [pcls_pkg::CNT_OUT_W-1:0] out_element_count,
  output logic signed      [pcls_pkg::VAL_W-1:0]     out_read_value,
  output logic signed      [pcls_pkg::VAL_W-1:0]     out_successor_value
);

  pcls_pkg::cmd_t cmd;
  pcls_pkg::sts_t sts;

  pcls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcls_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_operation        (in_operation),
    .in_position         (in_position),
    .in_value            (in_value),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_element_count   (out_element_count),
    .out_read_value      (out_read_value),
    .out_successor_value (out_successor_value)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Block took a second item while one was in progress.");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.exec, cmd.div_step, cmd.rd_first, cmd.rd_second, cmd.rev_load,
              cmd.rev_write_lo, cmd.rev_write_hi, cmd.load_out}))
    else $error("More than one datapath command in a cycle.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid && !out_ready))
    else $error("Result register loaded while a result was still waiting.");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == pcls_pkg::ST_EMPTY |->
      out_read_value == '0 && out_successor_value == '0)
    else $error("Empty-store result carries nonzero values.");

endmodule

`default_nettype wire
